// File: rtl/dvde_pkg.sv
// Shared constants and types for the distinct-value dictionary encoder.
package dvde_pkg;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int VALUE_W         = 64;
    localparam int CODE_W          = 7;
    localparam int CFG_W           = 7;
    localparam int COUNT_W         = 16;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;

    localparam logic [CFG_W-1:0]   MAX_ENTRIES_RST = 7'd64;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

    // Register index, taken from paddr[2] (32-bit registers on 4-byte steps)
    localparam logic REG_MAX_ENTRIES = 1'b0;

    // Probe that walks the cell chain
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
        logic               hit;
        logic [CODE_W-1:0]  code;
    } dvde_token_t;

endpackage

// File: rtl/distinct_value_dictionary_encoder.sv
// Top level of the distinct-value dictionary encoder.
// Each accepted element (start high while busy low) walks a chain of
// TABLE_DEPTH cells, one cell per cycle, each cell holding one table entry;
// its result is registered after the last cell and shows for one cycle,
// marked by result_valid, and busy drops in that same cycle, so a new
// element is taken only once the last one's result shows. Results cannot
// be held off by the receiver. max_entries is at APB byte address 0 and
// must only be written while busy is low.
module distinct_value_dictionary_encoder
    import dvde_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [APB_ADDR_W-1:0]  paddr,
    input  logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready,
    // element in
    input  logic                   start,
    output logic                   busy,
    input  logic [VALUE_W-1:0]     value,
    input  logic                   end_of_row,
    input  logic                   end_of_matrix,
    // result out
    output logic                   result_valid,
    output logic [CODE_W-1:0]      code,
    output logic                   coded,
    output logic                   new_entry,
    output logic [VALUE_W-1:0]     entry_value,
    output logic                   done_res,
    output logic [COUNT_W-1:0]     total_count
);

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(TABLE_DEPTH);

    // configuration register
    logic [CFG_W-1:0] max_entries_reg;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_ENTRIES);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= MAX_ENTRIES_RST;
        end
        else if (cfg_wr)
        begin
            max_entries_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_MAX_ENTRIES)
        begin
            prdata = APB_DATA_W'(max_entries_reg);
        end
    end

    // matrix state
    logic               busy_reg,     busy_next;
    logic [CNT_W-1:0]   n_stored_reg, n_stored_next;
    logic [COUNT_W-1:0] count_reg,    count_next;
    logic               overflow_reg, overflow_next;
    logic               halted_reg,   halted_next;
    logic               eor_reg;
    logic               eom_reg;

    logic [CMP_W-1:0]   limit;
    logic [CMP_W-1:0]   n_stored_ext;
    logic               accept;

    assign accept       = start && !busy_reg;
    assign busy         = busy_reg;
    assign limit        = (CMP_W'(max_entries_reg) > DEPTH_C) ? DEPTH_C
                                                              : CMP_W'(max_entries_reg);
    assign n_stored_ext = CMP_W'(n_stored_reg);

    // cell chain
    dvde_token_t        tok [0:TABLE_DEPTH];
    dvde_token_t        tok_end;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;

    assign tok[0] = {accept, value, 1'b0, {CODE_W{1'b0}}};

    for (genvar k = 0; k < TABLE_DEPTH; k++)
    begin : g_cell
        dvde_cell #(
            .TABLE_DEPTH (TABLE_DEPTH),
            .IDX         (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .n_stored (n_stored_reg),
            .wr_en    (wr_en),
            .wr_idx   (wr_idx),
            .wr_value (tok_end.value),
            .tok_in   (tok[k]),
            .tok_out  (tok[k+1])
        );
    end

    assign tok_end = tok[TABLE_DEPTH];

    // resolution at the end of the chain
    logic               nz;
    logic [CODE_W-1:0]  code_next;
    logic               coded_next;
    logic               fresh_next;
    logic [COUNT_W-1:0] bumped;

    assign nz     = |tok_end.value[VALUE_W-2:0];
    assign bumped = (count_reg == COUNT_MAX) ? count_reg : count_reg + 1'b1;
    assign wr_idx = IDX_W'(n_stored_reg);

    always_comb
    begin
        busy_next     = busy_reg;
        n_stored_next = n_stored_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        halted_next   = halted_reg;
        code_next     = '0;
        coded_next    = 1'b0;
        fresh_next    = 1'b0;
        wr_en         = 1'b0;

        if (accept)
        begin
            busy_next = 1'b1;
            // a full table at row start (or after a lowered limit) halts
            if (!halted_reg && !overflow_reg && (n_stored_ext >= limit))
            begin
                halted_next = 1'b1;
            end
        end

        if (tok_end.valid)
        begin
            busy_next = 1'b0;
            if (nz)
            begin
                if (tok_end.hit)
                begin
                    code_next  = tok_end.code;
                    coded_next = 1'b1;
                end
                else if (!halted_reg)
                begin
                    count_next = bumped;
                    if (!overflow_reg && (n_stored_ext < limit))
                    begin
                        wr_en         = 1'b1;
                        n_stored_next = n_stored_reg + 1'b1;
                        code_next     = CODE_W'(n_stored_reg + 1'b1);
                        coded_next    = 1'b1;
                        fresh_next    = 1'b1;
                        if ((n_stored_ext + 1'b1) >= limit)
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                end
            end

            if (eom_reg)
            begin
                n_stored_next = '0;
                count_next    = '0;
                overflow_next = 1'b0;
                halted_next   = 1'b0;
            end
            else if (eor_reg)
            begin
                if (overflow_next)
                begin
                    halted_next = 1'b1;
                end
                overflow_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            n_stored_reg <= '0;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            halted_reg   <= 1'b0;
            result_valid <= 1'b0;
        end
        else
        begin
            busy_reg     <= busy_next;
            n_stored_reg <= n_stored_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            halted_reg   <= halted_next;
            result_valid <= tok_end.valid;
        end
    end

    // count before the end-of-matrix clear
    function automatic logic [COUNT_W-1:0] count_next_pre_clear(
        input logic [COUNT_W-1:0] cur,
        input logic [COUNT_W-1:0] inc,
        input logic               nonzero,
        input logic               hit,
        input logic               stopped
    );
        logic [COUNT_W-1:0] res;
        res = cur;
        if (nonzero && !hit && !stopped)
        begin
            res = inc;
        end
        return res;
    endfunction

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            eor_reg <= end_of_row;
            eom_reg <= end_of_matrix;
        end
        if (tok_end.valid)
        begin
            code        <= code_next;
            coded       <= coded_next;
            new_entry   <= fresh_next;
            entry_value <= fresh_next ? tok_end.value : '0;
            done_res    <= eom_reg;
            total_count <= eom_reg ? count_next_pre_clear(count_reg, bumped, nz,
                                                         tok_end.hit, halted_reg)
                                   : '0;
        end
    end

endmodule

// File: rtl/dvde_cell.sv
// One table entry: holds a stored word and checks the passing probe against it.
module dvde_cell
    import dvde_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX         = 0,
    localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [CNT_W-1:0]   n_stored,
    input  logic               wr_en,
    input  logic [IDX_W-1:0]   wr_idx,
    input  logic [VALUE_W-1:0] wr_value,
    input  dvde_token_t        tok_in,
    output dvde_token_t        tok_out
);

    localparam logic [CNT_W-1:0]  POS      = CNT_W'(IDX);
    localparam logic [IDX_W-1:0]  POS_IDX  = IDX_W'(IDX);
    localparam logic [CODE_W-1:0] POS_CODE = CODE_W'(IDX + 1);

    logic [VALUE_W-1:0] entry_reg;
    logic               valid_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               hit_reg;
    logic [CODE_W-1:0]  code_reg;
    dvde_token_t        tok_next;
    logic               match;

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == POS_IDX))
        begin
            entry_reg <= wr_value;
        end
    end

    // Only entries below the stored count take part
    assign match = (POS < n_stored) && (entry_reg == tok_in.value);

    always_comb
    begin
        tok_next = tok_in;
        if (!tok_in.hit && match)
        begin
            tok_next.hit  = 1'b1;
            tok_next.code = POS_CODE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_next.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= tok_next.value;
        hit_reg   <= tok_next.hit;
        code_reg  <= tok_next.code;
    end

    assign tok_out = {valid_reg, value_reg, hit_reg, code_reg};

endmodule

// File: rtl/dvde_checker.sv
// Port-level checks for the dictionary encoder, bound to the top level.
module dvde_checker
    import dvde_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               result_valid,
    input logic [CODE_W-1:0]  code,
    input logic               coded,
    input logic               new_entry,
    input logic [VALUE_W-1:0] entry_value,
    input logic               done_res,
    input logic [COUNT_W-1:0] total_count
);

    // an accepted transaction raises busy (the design keeps it until the result)
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted transaction");

    a_result_frees: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while still busy");

    a_uncoded_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !coded) |-> ((code == '0) && !new_entry))
        else $error("code or new entry without coded");

    a_entry_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !new_entry) |-> (entry_value == '0))
        else $error("entry value without new entry");

    a_count_done: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !done_res) |-> (total_count == '0))
        else $error("total count outside end of matrix");

endmodule

bind distinct_value_dictionary_encoder dvde_checker u_dvde_checker (.*);
